// ----- hdl/mts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_POP_LOAD
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/min_tracking_stack_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stack of signed 32-bit values that also reports its running minimum. Each
// input transaction is a push (tuser = 0, value in tdata) or a pop (tuser = 1)
// and returns exactly one result transaction: the top and the minimum after the
// operation (both zero when the stack is empty), an empty flag and a status
// (0 ok, 1 push refused because the stack is full, 2 pop refused because it is
// empty; a refused operation changes nothing). Entries live in two
// single-port-write, registered-read memories of STACK_DEPTH words (values and
// running minima); the current top of each is cached in a register. A push, a
// refused push and a refused pop are answered from the cached tops. A pop that
// removes an entry also visits S_POP_LOAD while the registered-read memories
// fetch the new tops. The result sits in an output register, so the next
// transaction is taken in the cycle that the previous result is taken. No
// clearing pass is needed after reset: only entries below the counts are used.
module min_tracking_stack_unit (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] push_value
    input  wire  [0:0]  s_tuser,   // [0] opcode

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata    // [31:0] top_value, [63:32] min_value,
                                   // [64] is_empty, [66:65] status, [71:67] zero
);

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    mts_pkg::word_t val_mem [mts_pkg::STACK_DEPTH];
    mts_pkg::word_t min_mem [mts_pkg::STACK_DEPTH];

    mts_pkg::word_t val_rdata_reg;
    mts_pkg::word_t min_rdata_reg;

    // ------------------------------------------------------------------
    // Control and cached tops
    // ------------------------------------------------------------------
    mts_pkg::state_t state_reg, state_next;

    mts_pkg::cnt_t  val_cnt_reg, val_cnt_next;
    mts_pkg::cnt_t  min_cnt_reg, min_cnt_next;
    mts_pkg::word_t top_reg,     top_next;
    mts_pkg::word_t min_top_reg, min_top_next;
    logic           pop_min_reg, pop_min_next;

    // output register
    logic             out_valid_reg;
    mts_pkg::word_t   out_top_reg;
    mts_pkg::word_t   out_min_reg;
    logic             out_empty_reg;
    mts_pkg::status_t out_status_reg;

    logic             accept;
    mts_pkg::opcode_t op;
    mts_pkg::word_t   push_val;
    logic             out_free;
    logic             rd_en;
    logic             val_we;
    logic             min_we;
    logic             res_load;
    mts_pkg::status_t res_status;
    mts_pkg::addr_t   val_rd_addr;
    mts_pkg::addr_t   min_rd_addr;

    assign op       = mts_pkg::opcode_t'(s_tuser[0]);
    assign push_val = s_tdata;
    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // new top lives one below the old top index, i.e. count - 2
    assign val_rd_addr = mts_pkg::addr_t'(val_cnt_reg - mts_pkg::cnt_t'(2));
    assign min_rd_addr = mts_pkg::addr_t'(min_cnt_reg - mts_pkg::cnt_t'(2));

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mts_pkg::S_IDLE: begin
                if (accept && op == mts_pkg::OP_POP && val_cnt_reg != '0) begin
                    state_next = mts_pkg::S_POP_LOAD;
                end
            end
            mts_pkg::S_POP_LOAD: begin
                state_next = mts_pkg::S_IDLE;
            end
            default: begin
                state_next = mts_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        unique case (state_reg)
            mts_pkg::S_IDLE: begin
                s_tready = out_free;
                rd_en    = accept && op == mts_pkg::OP_POP;
            end
            mts_pkg::S_POP_LOAD: begin
                s_tready = 1'b0;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath: counts, cached tops, memory writes
    // ------------------------------------------------------------------
    always_comb begin
        val_cnt_next = val_cnt_reg;
        min_cnt_next = min_cnt_reg;
        top_next     = top_reg;
        min_top_next = min_top_reg;
        pop_min_next = pop_min_reg;
        val_we       = 1'b0;
        min_we       = 1'b0;
        res_load     = 1'b0;
        res_status   = mts_pkg::ST_OK;

        if (accept) begin
            if (op == mts_pkg::OP_PUSH) begin
                res_load = 1'b1;
                if (val_cnt_reg == mts_pkg::cnt_t'(mts_pkg::STACK_DEPTH)) begin
                    res_status = mts_pkg::ST_FULL;
                end else begin
                    val_we       = 1'b1;
                    top_next     = push_val;
                    val_cnt_next = val_cnt_reg + mts_pkg::cnt_t'(1);
                    // min count never exceeds value count, so there is room
                    if (min_cnt_reg == '0 || $signed(push_val) <= $signed(min_top_reg)) begin
                        min_we       = 1'b1;
                        min_top_next = push_val;
                        min_cnt_next = min_cnt_reg + mts_pkg::cnt_t'(1);
                    end
                end
            end else begin
                if (val_cnt_reg == '0) begin
                    res_load   = 1'b1;
                    res_status = mts_pkg::ST_EMPTY;
                end else begin
                    val_cnt_next = val_cnt_reg - mts_pkg::cnt_t'(1);
                    pop_min_next = (min_cnt_reg != '0) && (min_top_reg == top_reg);
                    if (pop_min_next) begin
                        min_cnt_next = min_cnt_reg - mts_pkg::cnt_t'(1);
                    end
                end
            end
        end

        // S_POP_LOAD state of a pop: new tops come back from the memories
        if (state_reg == mts_pkg::S_POP_LOAD) begin
            res_load = 1'b1;
            top_next = val_rdata_reg;
            if (pop_min_reg) begin
                min_top_next = min_rdata_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[mts_pkg::addr_t'(val_cnt_reg)] <= push_val;
        end
        if (rd_en) begin
            val_rdata_reg <= val_mem[val_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (min_we) begin
            min_mem[mts_pkg::addr_t'(min_cnt_reg)] <= push_val;
        end
        if (rd_en) begin
            min_rdata_reg <= min_mem[min_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mts_pkg::S_IDLE;
            val_cnt_reg   <= '0;
            min_cnt_reg   <= '0;
            pop_min_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            val_cnt_reg <= val_cnt_next;
            min_cnt_reg <= min_cnt_next;
            pop_min_reg <= pop_min_next;
            if (res_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: cached tops and result fields
    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        min_top_reg <= min_top_next;
        if (res_load) begin
            out_status_reg <= res_status;
            out_empty_reg  <= (val_cnt_next == '0);
            out_top_reg    <= (val_cnt_next == '0) ? '0 : top_next;
            out_min_reg    <= (val_cnt_next == '0 || min_cnt_next == '0) ? '0 : min_top_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_empty_reg, out_min_reg, out_top_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_min_le_val: assert property (@(posedge aclk) disable iff (!aresetn)
        min_cnt_reg <= val_cnt_reg)
        else $error("minimum stack deeper than value stack");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        val_cnt_reg <= mts_pkg::cnt_t'(mts_pkg::STACK_DEPTH))
        else $error("value count beyond stack depth");

    a_load_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mts_pkg::S_POP_LOAD |-> !out_valid_reg)
        else $error("pop result would overwrite a pending result");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mts_pkg::S_POP_LOAD |-> $past(val_cnt_reg) == val_cnt_reg + mts_pkg::cnt_t'(1))
        else $error("pop did not remove exactly one entry");

endmodule

`default_nettype wire
